@@ design/bpa_pkg.sv @@
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

  localparam logic [1:0] OP_FREE  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic CFG_SHIFT = 1'b0;
  localparam logic CFG_TOP   = 1'b1;

  localparam int unsigned SHIFT_MIN = 4;
  localparam int unsigned SHIFT_MAX = 20;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FREE_RD, S_FREE_WR, S_QUERY_RD, S_QUERY_DONE,
    S_ALLOC_RD, S_ALLOC_CHK, S_MARK_RD, S_MARK_WR, S_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic mem_rd;
    logic free_wr;
    logic free_adv;
    logic scan_step;
    logic mark_init;
    logic mark_wr;
    logic mark_adv;
    logic set_query;
    logic set_oom;
    logic set_zero;
    logic set_alloc_ok;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic [1:0] op;
    logic count_zero;
    logic hint_over;
    logic free_last;
    logic scan_found;
    logic scan_end;
    logic mark_last;
    logic out_busy;
  } stat_t;

endpackage

@@ design/bitmap_page_allocator.sv @@
// Top level of the bitmap page allocator.
//  channel | direction | content
//  s_axis  | in        | operation, page_address, page_count
//  m_axis  | out       | result_address, status, page_is_free
//  cfg     | in        | page_shift (0), top_page_address (1)
// One item at a time. Free reads and writes the bitmap word of each page in turn,
// query reads one bitmap word, and allocate scans bitmap words for a free run and
// then reads and writes the word of each page that it marks.
// After reset a clearing pass over the bitmap runs with no item accepted.
// The result register holds a result while m_axis_tready is low.
module bitmap_page_allocator #(
  parameter int unsigned BITMAP_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // operation, page_address, page_count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_address, status, page_is_free
);

  bpa_pkg::cmd_t  cmd;
  bpa_pkg::stat_t st;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .st(st), .cmd(cmd)
  );

  bpa_dp #(.BITMAP_WORDS(BITMAP_WORDS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_data(s_axis_tdata[44:0]), .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid), .out_data(m_axis_tdata), .cmd(cmd), .st(st)
  );

endmodule

@@ design/bpa_ctrl.sv @@
// Controller state machine for the bitmap page allocator.
module bpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bpa_pkg::stat_t  st,
  output bpa_pkg::cmd_t   cmd
);

  bpa_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      bpa_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_done) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = bpa_pkg::S_DONE;
          if (st.op == bpa_pkg::OP_FREE) begin
            state_next = bpa_pkg::S_FREE_RD;
          end else if (st.op == bpa_pkg::OP_QUERY) begin
            state_next = bpa_pkg::S_QUERY_RD;
          end else if (st.op == bpa_pkg::OP_ALLOC) begin
            state_next = bpa_pkg::S_ALLOC_RD;
          end
        end
      end
      bpa_pkg::S_FREE_RD: begin
        if (st.free_last) begin
          state_next = bpa_pkg::S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = bpa_pkg::S_FREE_WR;
        end
      end
      bpa_pkg::S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        cmd.free_adv = 1'b1;
        state_next = bpa_pkg::S_FREE_RD;
      end
      bpa_pkg::S_QUERY_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = bpa_pkg::S_QUERY_DONE;
      end
      bpa_pkg::S_QUERY_DONE: begin
        cmd.set_query = 1'b1;
        state_next = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_ALLOC_RD: begin
        if (st.count_zero) begin
          cmd.set_zero = 1'b1;
          state_next = bpa_pkg::S_DONE;
        end else if (st.hint_over || st.scan_end) begin
          cmd.set_oom = 1'b1;
          state_next = bpa_pkg::S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = bpa_pkg::S_ALLOC_CHK;
        end
      end
      bpa_pkg::S_ALLOC_CHK: begin
        if (st.scan_found) begin
          cmd.mark_init = 1'b1;
          cmd.set_alloc_ok = 1'b1;
          state_next = bpa_pkg::S_MARK_RD;
        end else begin
          cmd.scan_step = 1'b1;
          state_next = bpa_pkg::S_ALLOC_RD;
        end
      end
      bpa_pkg::S_MARK_RD: begin
        if (st.mark_last) begin
          state_next = bpa_pkg::S_DONE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_next = bpa_pkg::S_MARK_WR;
        end
      end
      bpa_pkg::S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        cmd.mark_adv = 1'b1;
        state_next = bpa_pkg::S_MARK_RD;
      end
      bpa_pkg::S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = bpa_pkg::S_IDLE;
        end
      end
      default: state_next = bpa_pkg::S_IDLE;
    endcase
  end

endmodule

@@ design/bpa_dp.sv @@
// Datapath for the bitmap page allocator: bitmap memory, scan and run logic.
module bpa_dp #(
  parameter int unsigned BITMAP_WORDS = 32768
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic [44:0]     in_data,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [39:0]     out_data,
  input  bpa_pkg::cmd_t   cmd,
  output bpa_pkg::stat_t  st
);

  localparam int unsigned AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam logic [AW:0] WORDS = (AW + 1)'(BITMAP_WORDS);
  localparam logic [63:0] TOTAL = 64'(BITMAP_WORDS) * 64'd32;

  logic [31:0] mem [BITMAP_WORDS];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [4:0]  page_shift;
  logic [31:0] top_addr;
  logic [31:0] hint;
  logic [4:0]  sh;

  logic [1:0]  op;
  logic [31:0] addr;
  logic [10:0] count;

  // Page cursor and run tracking; 33 bits cover page numbers up to 2^32.
  logic [32:0] p;
  logic [32:0] last_p;
  logic [32:0] fend;
  logic [10:0] run;
  logic [32:0] found;
  logic [32:0] start;
  logic [AW:0] clr_cnt;

  logic [31:0] res_addr;
  logic [1:0]  res_status;
  logic        res_free;

  // Effective shift with clamping.
  always_comb begin
    if (page_shift < 5'(bpa_pkg::SHIFT_MIN)) begin
      sh = 5'(bpa_pkg::SHIFT_MIN);
    end else if (page_shift > 5'(bpa_pkg::SHIFT_MAX)) begin
      sh = 5'(bpa_pkg::SHIFT_MAX);
    end else begin
      sh = page_shift;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= 5'd12;
      top_addr <= '0;
    end else if (cfg_we) begin
      if (cfg_index == bpa_pkg::CFG_SHIFT) begin
        page_shift <= cfg_data[4:0];
      end else begin
        top_addr <= cfg_data;
      end
    end
  end

  logic [32:0] last_raw;
  assign last_raw = 33'(top_addr >> sh);

  // Bitmap word read address follows the cursor or the query page.
  logic [32:0] qpage;
  assign qpage = 33'(addr >> sh);
  always_comb begin
    if (op == bpa_pkg::OP_QUERY) begin
      rd_addr = qpage[AW+4:5];
    end else begin
      rd_addr = p[AW+4:5];
    end
  end
  logic p_in_map;
  assign p_in_map = 64'(p) < TOTAL;

  // Scan of one word from the cursor up. The run ending at each bit comes
  // from the nearest used page at or below it, or from the carried run when there
  // is none, so every bit is judged in parallel.
  logic [10:0] run_n;
  logic [32:0] p_n;
  logic        hit;
  logic [32:0] hit_p;
  always_comb begin
    logic [31:0] zmask;
    logic [4:0]  klim;
    logic [4:0]  zpos;
    logic        zseen;
    logic [11:0] r;
    logic [4:0]  hk;
    zmask = ~rd_data;
    for (int j = 0; j < 32; j++) begin
      if (5'(j) < p[4:0]) begin
        zmask[j] = 1'b0;
      end
    end
    klim = (last_p[32:5] == p[32:5]) ? last_p[4:0] : 5'd31;
    hit = 1'b0;
    hk = '0;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      zseen = 1'b0;
      zpos = '0;
      for (int j = 0; j < 32; j++) begin
        if (j <= k && zmask[j]) begin
          zseen = 1'b1;
          zpos = 5'(j);
        end
      end
      if (zseen) begin
        r = 12'(5'(k) - zpos);
      end else begin
        r = 12'(run) + 12'(5'(k) - p[4:0]) + 12'd1;
      end
      if (!hit && 5'(k) >= p[4:0] && 5'(k) <= klim && r >= 12'(count)) begin
        hit = 1'b1;
        hk = 5'(k);
      end
    end
    run_n = r[10:0];
    hit_p = {p[32:5], hk};
    p_n = {p[32:5], 5'd0} + 33'd32;
  end

  // First page of the run that was found.
  assign found = hit_p + 33'd1 - 33'(count);

  // Memory write ports: clearing pass, free and mark.
  always_ff @(posedge clk) begin
    if (cmd.clear_step && clr_cnt != WORDS) begin
      mem[clr_cnt[AW-1:0]] <= '0;
    end else if (cmd.free_wr && p_in_map) begin
      mem[p[AW+4:5]] <= rd_data | (32'd1 << p[4:0]);
    end else if (cmd.mark_wr) begin
      mem[p[AW+4:5]] <= rd_data & ~(32'd1 << p[4:0]);
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control registers of the datapath.
  logic [32:0] nxt;
  assign nxt = (found + 33'(count));
  logic [63:0] nxt_sh;
  assign nxt_sh = 64'(nxt) << sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      hint <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step && clr_cnt != WORDS) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.load && in_data[1:0] == bpa_pkg::OP_FREE && in_data[33:2] < hint) begin
        hint <= 32'((in_data[33:2] >> sh) << sh);
      end
      if (cmd.set_alloc_ok && (found == start || count == 11'd1)) begin
        if (nxt_sh > 64'hFFFF_FFFF) begin
          hint <= 32'hFFFF_FFFF;
        end else begin
          hint <= nxt_sh[31:0];
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item, cursor and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_data[1:0];
      addr <= in_data[33:2];
      count <= in_data[44:34];
      run <= '0;
      res_addr <= '0;
      res_status <= bpa_pkg::ST_OK;
      res_free <= 1'b0;
      if (in_data[1:0] == bpa_pkg::OP_FREE) begin
        p <= 33'(in_data[33:2] >> sh);
        fend <= 33'(in_data[33:2] >> sh) + 33'(in_data[44:34]);
      end else begin
        p <= 33'(hint >> sh);
        start <= 33'(hint >> sh);
      end
      if (64'(last_raw) >= TOTAL) begin
        last_p <= 33'(TOTAL - 64'd1);
      end else begin
        last_p <= last_raw;
      end
    end
    if (cmd.free_adv) begin
      p <= p + 33'd1;
    end
    if (cmd.scan_step) begin
      p <= p_n;
      run <= run_n;
    end
    if (cmd.mark_init) begin
      p <= found;
      fend <= hit_p + 33'd1;
      res_addr <= 32'(64'(found) << sh);
    end
    if (cmd.mark_adv) begin
      p <= p + 33'd1;
    end
    if (cmd.set_query) begin
      res_free <= (64'(qpage) < TOTAL) ? rd_data[qpage[4:0]] : 1'b0;
    end
    if (cmd.set_oom) begin
      res_status <= bpa_pkg::ST_OOM;
    end
    if (cmd.set_zero) begin
      res_status <= bpa_pkg::ST_ZERO;
    end
    if (cmd.out_load) begin
      out_data <= {5'd0, res_free, res_status, res_addr};
    end
  end

  assign st.clear_done = clr_cnt == WORDS;
  assign st.op = in_data[1:0];
  assign st.count_zero = count == 11'd0;
  assign st.hint_over = hint > top_addr;
  assign st.free_last = p == fend;
  assign st.scan_found = hit;
  assign st.scan_end = p > last_p;
  assign st.mark_last = p == fend;
  assign st.out_busy = out_valid && !out_ready;

endmodule

@@ design/bpa_checker.sv @@
// Port-level checker for the bitmap page allocator and its bind.
module bpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No item accepted in the cycle after another.
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back to back accept");

  // Status code never takes the unused value.
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("bad status");

  // Query answer only with ok status and zero address.
  a_q: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[33:0] == 34'd0)
    else $error("bad query result");

endmodule

bind bitmap_page_allocator bpa_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
